/* sv/assert_macros.svh */
// Assertion macros shared by the sector residency ring manager RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked out of reset only.
`define SRRM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("srrm assertion failed");

// Checked at every edge, reset included.
`define SRRM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("srrm assertion failed");

`endif

/* sv/srrm_pkg.sv */
// Shared types, constants and ring tables for the ring manager.
// No dependencies.
package srrm_pkg;

    localparam int SLOT_COUNT = 9;
    localparam int SLOT_W     = 4;
    localparam int RING_COUNT = 9;
    localparam int POS_W      = 24;
    localparam int DIFF_W     = 25;
    localparam int CS_W       = 23;
    localparam int GRID_W     = 11;
    localparam int HYST_W     = 8;
    localparam int CELL_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_ACROSS = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_DOWN   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = 8'd5;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;
    localparam logic KIND_EVICT = 1'b0;
    localparam logic KIND_LOAD  = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_z;
        logic [CS_W-1:0]         cell_size;
        logic [GRID_W-1:0]       cells_across;
        logic [GRID_W-1:0]       cells_down;
        logic [HYST_W-1:0]       hysteresis;
    } cfg_t;

    typedef struct packed {
        logic                     cmd;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dz;
    } job_t;

    typedef struct packed {
        logic                     kind;
        logic [SLOT_W-1:0]        slot;
        logic signed [CELL_W-1:0] cell_x;
        logic signed [CELL_W-1:0] cell_z;
    } res_t;

    // Ring order: centre, then rows of increasing z, each in increasing x.
    function automatic logic signed [1:0] ring_dx(input logic [SLOT_W-1:0] k);
        case (k)
            4'd1, 4'd4, 4'd6: ring_dx = -2'sd1;
            4'd3, 4'd5, 4'd8: ring_dx = 2'sd1;
            default:          ring_dx = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] ring_dz(input logic [SLOT_W-1:0] k);
        case (k)
            4'd1, 4'd2, 4'd3: ring_dz = -2'sd1;
            4'd6, 4'd7, 4'd8: ring_dz = 2'sd1;
            default:          ring_dz = 2'sd0;
        endcase
    endfunction

endpackage

/* sv/sector_residency_ring_manager.sv */
// Top level of the sector residency ring manager: configuration registers and ports.
// Depends on srrm_pkg, srrm_front and srrm_back.
//
// Takes camera positions and keeps nine resident slots around the camera's grid
// cell. A clear request returns nothing. An update runs the hysteresis test
// (states S_HMUL to S_ZCMP, one multiplier shared between axes), two floor
// divisions on the single shared bit-serial divider, a nine-step eviction walk
// and a nine-step load walk, each step waiting while the result register is
// full, then a flush state that marks the last result. Updates inside the
// hysteresis window finish after the test. Requests are queued two deep ahead of
// the sequencer, so the input accepts while results wait. Configuration writes
// are taken every cycle and must only come while idle.
module sector_residency_ring_manager import srrm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // pos_x[23:0], pos_z[47:24]
    input  logic                  s_tuser,   // cmd
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // slot[3:0], cell_x[19:4], cell_z[35:20], zeros
    output logic                  m_tuser,   // kind
    output logic                  m_tlast    // last
);

    cfg_t cfg_reg;
    logic job_valid, job_pop;
    job_t job;
    res_t m_res;

    assign cfg_ready = 1'b1;

    // register file; unlisted indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_z     <= '0;
            cfg_reg.cell_size    <= CS_W'(256);
            cfg_reg.cells_across <= GRID_W'(1);
            cfg_reg.cells_down   <= GRID_W'(1);
            cfg_reg.hysteresis   <= HYST_W'(32);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ORIGIN_X:     cfg_reg.origin_x     <= cfg_data[POS_W-1:0];
                CFG_ORIGIN_Z:     cfg_reg.origin_z     <= cfg_data[POS_W-1:0];
                CFG_CELL_SIZE:    cfg_reg.cell_size    <= cfg_data[CS_W-1:0];
                CFG_CELLS_ACROSS: cfg_reg.cells_across <= cfg_data[GRID_W-1:0];
                CFG_CELLS_DOWN:   cfg_reg.cells_down   <= cfg_data[GRID_W-1:0];
                CFG_HYSTERESIS:   cfg_reg.hysteresis   <= cfg_data[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    // front: origin offset and two-deep request queue
    srrm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_cmd     (s_tuser),
        .s_pos_x   (s_tdata[23:0]),
        .s_pos_z   (s_tdata[47:24]),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    // back: hysteresis, division, evict and load walks
    srrm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res),
        .m_last    (m_tlast)
    );

    assign m_tdata = {4'b0, m_res.cell_z, m_res.cell_x, m_res.slot};
    assign m_tuser = m_res.kind;

endmodule

/* sv/srrm_front.sv */
// Front end: accepts requests, offsets positions by the origin and queues them.
// Depends on srrm_pkg.
module srrm_front import srrm_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_cmd,
    input  logic signed [POS_W-1:0] s_pos_x,
    input  logic signed [POS_W-1:0] s_pos_z,
    output logic                    job_valid,
    output job_t                    job,
    input  logic                    job_pop
);

    job_t       q_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push;
    job_t       in_job;

    assign s_tready  = (count_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_mem[rd_ptr_reg];

    always_comb begin
        in_job.cmd = s_cmd;
        in_job.dx  = DIFF_W'(s_pos_x) - DIFF_W'(cfg.origin_x);
        in_job.dz  = DIFF_W'(s_pos_z) - DIFF_W'(cfg.origin_z);
        count_next = count_reg + 2'(push) - 2'(job_pop && job_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (job_pop && job_valid) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
        if (push) begin
            q_mem[wr_ptr_reg] <= in_job;
        end
    end

endmodule

/* sv/srrm_div.sv */
// Iterative floor divider, one quotient bit a cycle, result saturated to 16 bits.
// Depends on srrm_pkg.
module srrm_div import srrm_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] dividend,
    input  logic [CS_W-1:0]          divisor,
    output logic                     done,
    output logic signed [CELL_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIFF_W + 1);

    logic              busy_reg, done_reg, neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIFF_W-1:0] mag_reg;
    logic [CS_W:0]     rem_reg;
    logic [CS_W-1:0]   div_reg;
    logic signed [CELL_W-1:0] quot_reg;

    logic [CS_W+1:0]       shifted;
    logic                  fits;
    logic signed [DIFF_W:0] qf;

    always_comb begin
        shifted = {rem_reg, mag_reg[DIFF_W-1]};
        fits    = (shifted >= {2'b00, div_reg});
        qf      = $signed({1'b0, mag_reg});
        if (neg_reg) begin
            qf = -(qf + (DIFF_W+1)'(rem_reg != '0));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIFF_W);
                neg_reg  <= dividend[DIFF_W-1];
                mag_reg  <= dividend[DIFF_W-1] ? DIFF_W'(-dividend) : DIFF_W'(dividend);
                rem_reg  <= '0;
                div_reg  <= divisor;
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                    mag_reg <= {mag_reg[DIFF_W-2:0], fits};
                    rem_reg <= fits ? (CS_W+1)'(shifted - {2'b00, div_reg})
                                    : (CS_W+1)'(shifted);
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (qf > 32767) begin
                        quot_reg <= 16'sh7fff;
                    end else if (qf < -32768) begin
                        quot_reg <= -16'sh8000;
                    end else begin
                        quot_reg <= CELL_W'(qf);
                    end
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* sv/srrm_back.sv */
// Back end: hysteresis test, cell division, evict and load walks, result register.
// Depends on srrm_pkg, srrm_div and assert_macros.svh.
`include "assert_macros.svh"
module srrm_back import srrm_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  job_valid,
    input  job_t  job,
    output logic  job_pop,
    output logic  m_valid,
    input  logic  m_ready,
    output res_t  m_res,
    output logic  m_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_HMUL, S_XMUL, S_XCMP, S_ZCMP, S_DIVX, S_DIVZ, S_EVICT, S_LOAD, S_FLUSH
    } state_t;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [SLOT_W-1:0] RING_LAST = SLOT_W'(RING_COUNT - 1);

    state_t state_reg;
    logic signed [DIFF_W-1:0] dx_reg, dz_reg;
    logic [CS_W-1:0]          c_reg;
    logic [31:0]              hw_reg;
    logic signed [40:0]       pm_reg;
    logic                     near_x_reg;
    logic signed [CELL_W-1:0] cx_reg, centre_x_reg, centre_z_reg;
    logic                     primed_reg;
    logic [SLOT_W-1:0]        idx_reg;
    logic [SLOT_COUNT-1:0]    busy_reg;
    logic signed [CELL_W-1:0] slot_x_reg [SLOT_COUNT];
    logic signed [CELL_W-1:0] slot_z_reg [SLOT_COUNT];
    logic                     pend_valid_reg, m_valid_reg, m_last_reg;
    res_t                     pend_reg, m_res_reg;

    logic                     div_start, div_done;
    logic signed [CELL_W-1:0] div_q;
    logic signed [DIFF_W-1:0] div_dividend;

    logic signed [DIFF_W-1:0] d_sel;
    logic signed [CELL_W-1:0] cc_sel;
    logic signed [40:0]       pm_w;
    logic [31:0]              hw_w;
    logic signed [48:0]       diff_w, adiff_w;
    logic                     near_now;
    logic signed [17:0]       ex, ez;
    logic                     outside;
    logic signed [16:0]       tx, tz;
    logic                     in_grid, resident, free_found, need_load;
    logic [SLOT_W-1:0]        free_idx;
    logic                     out_free, can_emit, emit_req, flush_req, load_out;
    res_t                     emit_res;

    srrm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (c_reg),
        .done     (div_done),
        .quot     (div_q)
    );

    always_comb begin
        d_sel   = (state_reg == S_ZCMP) ? dz_reg : dx_reg;
        cc_sel  = (state_reg == S_XMUL) ? centre_x_reg : centre_z_reg;
        pm_w    = $signed({cc_sel, 1'b1}) * $signed({1'b0, c_reg});
        hw_w    = 32'({1'b0, cfg.hysteresis} + 9'd128) * 32'(c_reg);
        diff_w  = (49'(d_sel) <<< 8) - (49'(pm_reg) <<< 7);
        adiff_w = diff_w[48] ? -diff_w : diff_w;
        near_now = (adiff_w <= $signed({17'b0, hw_reg}));

        div_start    = (state_reg == S_ZCMP && !(primed_reg && near_x_reg && near_now))
                    || (state_reg == S_DIVX && div_done);
        div_dividend = (state_reg == S_DIVX) ? dz_reg : dx_reg;

        ex = 18'(slot_x_reg[idx_reg]) - 18'(centre_x_reg);
        ez = 18'(slot_z_reg[idx_reg]) - 18'(centre_z_reg);
        outside = (ex > 1) || (ex < -1) || (ez > 1) || (ez < -1);

        tx = 17'(centre_x_reg) + 17'(ring_dx(idx_reg));
        tz = 17'(centre_z_reg) + 17'(ring_dz(idx_reg));
        in_grid = !tx[16] && !tz[16]
               && (tx < $signed({6'b0, cfg.cells_across}))
               && (tz < $signed({6'b0, cfg.cells_down}));
        resident = 1'b0;
        for (int j = 0; j < SLOT_COUNT; j++) begin
            if (busy_reg[j] && 17'(slot_x_reg[j]) == tx && 17'(slot_z_reg[j]) == tz) begin
                resident = 1'b1;
            end
        end
        free_found = 1'b0;
        free_idx   = '0;
        for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
            if (!busy_reg[j]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(j);
            end
        end
        need_load = in_grid && !resident && free_found;

        emit_res.kind   = (state_reg == S_LOAD) ? KIND_LOAD : KIND_EVICT;
        emit_res.slot   = (state_reg == S_LOAD) ? free_idx : idx_reg;
        emit_res.cell_x = (state_reg == S_LOAD) ? CELL_W'(tx) : slot_x_reg[idx_reg];
        emit_res.cell_z = (state_reg == S_LOAD) ? CELL_W'(tz) : slot_z_reg[idx_reg];

        emit_req  = (state_reg == S_EVICT && busy_reg[idx_reg] && outside)
                 || (state_reg == S_LOAD && need_load);
        flush_req = (state_reg == S_FLUSH) && pend_valid_reg;
        out_free  = !m_valid_reg || m_ready;
        can_emit  = !pend_valid_reg || out_free;
        load_out  = out_free && pend_valid_reg && ((emit_req && can_emit) || flush_req);
        job_pop   = (state_reg == S_IDLE) && job_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            busy_reg       <= '0;
            primed_reg     <= 1'b0;
            centre_x_reg   <= -16'sd32767;
            centre_z_reg   <= -16'sd32767;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            idx_reg        <= '0;
        end else begin
            // result register and one-deep hold-back that decides last
            if (load_out) begin
                m_valid_reg <= 1'b1;
                m_res_reg   <= pend_reg;
                m_last_reg  <= flush_req;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit_req && can_emit) begin
                pend_reg       <= emit_res;
                pend_valid_reg <= 1'b1;
            end else if (flush_req && out_free) begin
                pend_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        if (job.cmd == CMD_CLEAR) begin
                            busy_reg     <= '0;
                            primed_reg   <= 1'b0;
                            centre_x_reg <= -16'sd32767;
                            centre_z_reg <= -16'sd32767;
                        end else begin
                            dx_reg    <= job.dx;
                            dz_reg    <= job.dz;
                            c_reg     <= (cfg.cell_size == '0) ? CS_W'(1) : cfg.cell_size;
                            state_reg <= S_HMUL;
                        end
                    end
                end
                S_HMUL: begin
                    hw_reg    <= hw_w;
                    state_reg <= S_XMUL;
                end
                S_XMUL: begin
                    pm_reg    <= pm_w;
                    state_reg <= S_XCMP;
                end
                S_XCMP: begin
                    near_x_reg <= near_now;
                    pm_reg     <= pm_w;
                    state_reg  <= S_ZCMP;
                end
                S_ZCMP: begin
                    state_reg <= div_start ? S_DIVX : S_IDLE;
                end
                S_DIVX: begin
                    if (div_done) begin
                        cx_reg    <= div_q;
                        state_reg <= S_DIVZ;
                    end
                end
                S_DIVZ: begin
                    if (div_done) begin
                        centre_x_reg <= cx_reg;
                        centre_z_reg <= div_q;
                        primed_reg   <= 1'b1;
                        idx_reg      <= '0;
                        state_reg    <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    if (!emit_req || can_emit) begin
                        if (emit_req) begin
                            busy_reg[idx_reg] <= 1'b0;
                        end
                        if (idx_reg == SLOT_LAST) begin
                            idx_reg   <= '0;
                            state_reg <= S_LOAD;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_LOAD: begin
                    if (!emit_req || can_emit) begin
                        if (emit_req) begin
                            busy_reg[free_idx]   <= 1'b1;
                            slot_x_reg[free_idx] <= CELL_W'(tx);
                            slot_z_reg[free_idx] <= CELL_W'(tz);
                        end
                        if (idx_reg == RING_LAST) begin
                            state_reg <= S_FLUSH;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!pend_valid_reg || out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;
    assign m_last  = m_last_reg;

    `SRRM_ASSERT(a_idle_no_pend, aclk, aresetn, (state_reg == S_IDLE) |-> !pend_valid_reg)
    `SRRM_ASSERT(a_div_seq, aclk, aresetn, div_start |=> (state_reg == S_DIVX || state_reg == S_DIVZ))
    `SRRM_ASSERT(a_walk_primed, aclk, aresetn, (state_reg == S_EVICT || state_reg == S_LOAD) |-> primed_reg)
    `SRRM_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> (state_reg == S_IDLE && !m_valid_reg))

endmodule
